// ===== src/gfa_pkg.sv =====
// Shared types, constants, the GF(2^15) multiply function and a bit-reverse function.
// No dependencies.
package gfa_pkg;

    localparam int FieldBits = 15;
    localparam int ProdBits  = 2 * FieldBits - 1;
    localparam int InvSteps  = 2 * (FieldBits - 1);

    typedef logic [FieldBits-1:0] elem_t;
    typedef logic [2:0]           opcode_t;

    localparam opcode_t OP_ADD = 3'd0;
    localparam opcode_t OP_MUL = 3'd1;
    localparam opcode_t OP_INV = 3'd2;
    localparam opcode_t OP_DIV = 3'd3;
    localparam opcode_t OP_REV = 3'd4;

    typedef enum logic [1:0] {
        KIND_DONE,
        KIND_INV,
        KIND_DIV
    } kind_t;

    typedef struct packed {
        kind_t kind;
        elem_t x;    // element to invert
        elem_t aux;  // finished result, or dividend
    } entry_t;

    // carry-less product, one fold of bits 15..28 using z^15 = z + 1
    function automatic elem_t gf_mul(elem_t x, elem_t y);
        logic [ProdBits-1:0] prod;
        logic [ProdBits-1:0] hi;
        logic [ProdBits-1:0] folded;
        prod = '0;
        for (int k = 0; k < FieldBits; k++)
        begin
            if (y[k])
            begin
                prod = prod ^ ({{(FieldBits-1){1'b0}}, x} << k);
            end
        end
        hi = {prod[ProdBits-1:FieldBits], {FieldBits{1'b0}}};
        folded = prod ^ (hi >> (FieldBits - 1)) ^ (hi >> FieldBits);
        return folded[FieldBits-1:0];
    endfunction

    function automatic elem_t bit_rev(elem_t v);
        elem_t r;
        for (int k = 0; k < FieldBits; k++)
        begin
            r[k] = v[FieldBits-1-k];
        end
        return r;
    endfunction

endpackage

// ===== src/gfa_if.sv =====
// Request and response channel interfaces (valid/ready).
// Depends on gfa_pkg.
interface gfa_req_if import gfa_pkg::*;;
    logic    valid;
    logic    ready;
    opcode_t req_type;
    elem_t   operand_a;
    elem_t   operand_b;
    modport source (output valid, output req_type, output operand_a, output operand_b,
                    input ready);
    modport sink (input valid, input req_type, input operand_a, input operand_b,
                  output ready);
endinterface

interface gfa_rsp_if import gfa_pkg::*;;
    logic  valid;
    logic  ready;
    elem_t result_value;
    modport source (output valid, output result_value, input ready);
    modport sink (input valid, input result_value, output ready);
endinterface

// ===== src/gfa_front.sv =====
// Front end: decodes a request beat and finishes add, multiply and reverse.
// Depends on gfa_pkg and gfa_if.
module gfa_front
    import gfa_pkg::*;
(
    gfa_req_if.sink req,
    input  logic    full,
    output logic    push,
    output entry_t  entry
);

    always_comb
    begin
        entry.kind = KIND_DONE;
        entry.x    = req.operand_b;
        entry.aux  = '0;
        unique case (req.req_type)
            OP_ADD: entry.aux = req.operand_a ^ req.operand_b;
            OP_MUL: entry.aux = gf_mul(req.operand_a, req.operand_b);
            OP_INV:
            begin
                entry.kind = KIND_INV;
                entry.x    = req.operand_a;
            end
            OP_DIV:
            begin
                entry.kind = KIND_DIV;
                entry.aux  = req.operand_a;
            end
            OP_REV: entry.aux = bit_rev(req.operand_a);
            default: entry.aux = '0;
        endcase
    end

    assign req.ready = !full;
    assign push      = req.valid && !full;

endmodule

// ===== src/gfa_queue.sv =====
// Two-entry queue between front and back end.
// Depends on gfa_pkg.
module gfa_queue
    import gfa_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   nonempty,
    output entry_t head
);

    entry_t     mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    assign full     = (count_reg == 2'd2);
    assign nonempty = (count_reg != 2'd0);
    assign head     = mem_reg[rd_ptr_reg];
    assign do_pop   = pop && nonempty;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3) else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push) else $error("push into full queue");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

// ===== src/gfa_back.sv =====
// Back end: 28-stage multiply/square chain for a^(2^15-2), then a final
// multiply for divide. Depends on gfa_pkg and gfa_if.
module gfa_back
    import gfa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  entry_t  in_entry,
    output logic    pop,
    gfa_rsp_if.source rsp
);

    localparam int Last = InvSteps;

    logic   vld_reg  [Last+1];
    entry_t ent_reg  [Last+1];
    elem_t  acc_reg  [Last];
    elem_t  acc_next [Last];
    elem_t  final_next;
    logic   adv;

    assign adv = !vld_reg[Last] || rsp.ready;
    assign pop = adv;

    for (genvar k = 0; k < Last; k++)
    begin : g_step
        elem_t acc_in;
        elem_t x_in;
        if (k == 0)
        begin : g_first
            assign acc_in = elem_t'(1);
            assign x_in   = in_entry.x;
        end
        else
        begin : g_rest
            assign acc_in = acc_reg[k-1];
            assign x_in   = ent_reg[k-1].x;
        end
        if (k % 2 == 0)
        begin : g_mul
            assign acc_next[k] = gf_mul(acc_in, x_in);
        end
        else
        begin : g_sq
            assign acc_next[k] = gf_mul(acc_in, acc_in);
        end
    end

    always_comb
    begin
        unique case (ent_reg[Last-1].kind)
            KIND_INV: final_next = acc_reg[Last-1];
            KIND_DIV: final_next = gf_mul(ent_reg[Last-1].aux, acc_reg[Last-1]);
            default:  final_next = ent_reg[Last-1].aux;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= Last; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= Last; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ent_reg[0] <= in_entry;
            acc_reg[0] <= acc_next[0];
            for (int k = 1; k < Last; k++)
            begin
                ent_reg[k] <= ent_reg[k-1];
                acc_reg[k] <= acc_next[k];
            end
            ent_reg[Last] <= {ent_reg[Last-1].kind, ent_reg[Last-1].x, final_next};
        end
    end

    assign rsp.valid        = vld_reg[Last];
    assign rsp.result_value = ent_reg[Last].aux;

    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.result_value)))
        else $error("result changed under stall");
    a_pop_adv: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[Last] && !rsp.ready) |-> !pop) else $error("pop while stalled");
    a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[Last-1] && ent_reg[Last-1].kind == KIND_INV && ent_reg[Last-1].x == '0)
        |-> (acc_reg[Last-1] == '0)) else $error("inverse of zero not zero");

endmodule

// ===== src/gf2_15_field_alu_core.sv =====
// GF(2^15) ALU top level: front decode, two-entry queue, inversion pipeline.
// Path from request beat to result beat: queue register, 28 multiply/square stages,
// final multiply into output reg; the pipeline stalls while a result waits on rsp.ready.
// Throughput: one request per cycle while rsp.ready is high; each pipeline stage holds one multiplier.
// Reset: rst_n async active low clears queue and pipeline valid bits.
// Depends on gfa_pkg, gfa_if, gfa_front, gfa_queue, gfa_back.
module gf2_15_field_alu_core
    import gfa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    gfa_req_if.sink   req,
    gfa_rsp_if.source rsp
);

    logic   full;
    logic   push;
    entry_t push_data;
    logic   pop;
    logic   nonempty;
    entry_t head;

    gfa_front u_front (
        .req   (req),
        .full  (full),
        .push  (push),
        .entry (push_data)
    );

    gfa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .nonempty  (nonempty),
        .head      (head)
    );

    gfa_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (nonempty),
        .in_entry (head),
        .pop      (pop),
        .rsp      (rsp)
    );

endmodule

// ===== sim/gfa_tb_if.sv =====
`timescale 1ns / 100ps
// Testbench copy point for the channel interfaces: none needed beyond src/gfa_if.sv.
// Holds the stimulus row type used by the testbench; depends on gfa_pkg.
package gfa_tb_pkg;
    import gfa_pkg::*;

    typedef struct {
        opcode_t op;
        elem_t   a;
        elem_t   b;
        logic    known;   // expected value typed in the table
        elem_t   want;
    } stim_row_t;
endpackage

// ===== sim/gf2_15_field_alu_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench for gf2_15_field_alu_core: directed table then random requests,
// results checked in order against an in-bench GF(2^15) predictor.
// Depends on gfa_pkg, gfa_if, gfa_tb_pkg and the RTL.
module gf2_15_field_alu_core_tb;
    import gfa_pkg::*;
    import gfa_tb_pkg::*;

    localparam int RandItems = 1100;
    localparam int CycleLimit = 200000;
    localparam opcode_t OP_BAD5 = 3'd5;
    localparam opcode_t OP_BAD6 = 3'd6;
    localparam opcode_t OP_BAD7 = 3'd7;

    logic clk;
    logic rst_n;
    int   errors;
    int   cycles;
    logic feed_done;
    elem_t want_q[$];

    gfa_req_if req ();
    gfa_rsp_if rsp ();

    gf2_15_field_alu_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic elem_t field_mul(elem_t x, elem_t y);
        logic [28:0] p;
        logic [28:0] hi;
        p = '0;
        for (int k = 0; k < 15; k++)
        begin
            if (y[k])
            begin
                p = p ^ (29'(x) << k);
            end
        end
        hi = p & 29'h1FFF8000;
        p = p ^ (hi >> 14) ^ (hi >> 15);
        return p[14:0];
    endfunction

    function automatic elem_t field_inv(elem_t x);
        elem_t acc;
        acc = 15'd1;
        for (int r = 0; r < 14; r++)
        begin
            acc = field_mul(acc, x);
            acc = field_mul(acc, acc);
        end
        return acc;
    endfunction

    function automatic elem_t alu_result(opcode_t op, elem_t a, elem_t b);
        elem_t r;
        case (op)
            OP_ADD: r = a ^ b;
            OP_MUL: r = field_mul(a, b);
            OP_INV: r = field_inv(a);
            OP_DIV: r = field_mul(a, field_inv(b));
            OP_REV:
            begin
                for (int k = 0; k < 15; k++)
                begin
                    r[k] = a[14-k];
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    // directed rows; want typed where obvious
    stim_row_t dir_rows[] = '{
        '{OP_ADD, 15'h0000, 15'h0000, 1'b1, 15'h0000},
        '{OP_ADD, 15'h7FFF, 15'h0000, 1'b1, 15'h7FFF},
        '{OP_ADD, 15'h7FFF, 15'h7FFF, 1'b1, 15'h0000},
        '{OP_ADD, 15'h5555, 15'h2AAA, 1'b1, 15'h7FFF},
        '{OP_MUL, 15'h0000, 15'h7FFF, 1'b1, 15'h0000},
        '{OP_MUL, 15'h0001, 15'h7FFF, 1'b1, 15'h7FFF},
        '{OP_MUL, 15'h7FFF, 15'h7FFF, 1'b0, 15'h0000},
        '{OP_MUL, 15'h4000, 15'h0002, 1'b1, 15'h0003},
        '{OP_MUL, 15'h4000, 15'h4000, 1'b0, 15'h0000},
        '{OP_INV, 15'h0000, 15'h1234, 1'b1, 15'h0000},
        '{OP_INV, 15'h0001, 15'h0000, 1'b1, 15'h0001},
        '{OP_INV, 15'h7FFF, 15'h7FFF, 1'b0, 15'h0000},
        '{OP_INV, 15'h0002, 15'h0000, 1'b0, 15'h0000},
        '{OP_DIV, 15'h1234, 15'h0000, 1'b1, 15'h0000},
        '{OP_DIV, 15'h7FFF, 15'h0001, 1'b1, 15'h7FFF},
        '{OP_DIV, 15'h0000, 15'h7FFF, 1'b1, 15'h0000},
        '{OP_DIV, 15'h7FFF, 15'h7FFF, 1'b1, 15'h0001},
        '{OP_DIV, 15'h0001, 15'h4000, 1'b0, 15'h0000},
        '{OP_REV, 15'h0001, 15'h0000, 1'b1, 15'h4000},
        '{OP_REV, 15'h7FFF, 15'h7FFF, 1'b1, 15'h7FFF},
        '{OP_REV, 15'h0000, 15'h7FFF, 1'b1, 15'h0000},
        '{OP_REV, 15'h0F00, 15'h0000, 1'b1, 15'h0078},
        '{OP_BAD5, 15'h7FFF, 15'h7FFF, 1'b1, 15'h0000},
        '{OP_BAD6, 15'h1234, 15'h4321, 1'b1, 15'h0000},
        '{OP_BAD7, 15'h7FFF, 15'h7FFF, 1'b1, 15'h0000}
    };

    task automatic send_beat(opcode_t op, elem_t a, elem_t b, logic known, elem_t want);
        int gap;
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0)
        begin
            gap = 0;
        end
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.req_type  <= op;
        req.operand_a <= a;
        req.operand_b <= b;
        do
        begin
            @(posedge clk);
        end
        while (!req.ready);
        if (known && want != alu_result(op, a, b))
        begin
            $display("%0t: table row op %0d disagrees with predictor", $time, op);
            errors++;
        end
        want_q.push_back(known ? want : alu_result(op, a, b));
    endtask

    initial
    begin
        opcode_t op;
        elem_t   a;
        elem_t   b;
        errors        = 0;
        feed_done     = 1'b0;
        rst_n         = 1'b0;
        req.valid     = 1'b0;
        req.req_type  = '0;
        req.operand_a = '0;
        req.operand_b = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_rows[i])
        begin
            send_beat(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b,
                      dir_rows[i].known, dir_rows[i].want);
        end
        for (int n = 0; n < RandItems; n++)
        begin
            op = opcode_t'($urandom_range(0, 9) < 9 ? $urandom_range(0, 4)
                                                    : $urandom_range(5, 7));
            a = elem_t'($urandom);
            b = elem_t'($urandom);
            case ($urandom_range(0, 9))
                0: a = '0;
                1: b = '0;
                2: a = '1;
                3: b = '1;
                default: ;
            endcase
            send_beat(op, a, b, 1'b0, '0);
        end
        req.valid <= 1'b0;
        feed_done <= 1'b1;
    end

    // receiver: random stalls plus one long hold-off
    initial
    begin
        int wait_n;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        repeat (300) @(posedge clk);
        rsp.ready <= 1'b1;
        forever
        begin
            wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
            if (wait_n > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (want_q.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $time, rsp.result_value);
                errors++;
            end
            else
            begin
                if (rsp.result_value !== want_q[0])
                begin
                    $display("%0t: result mismatch expected %h actual %h",
                             $time, want_q[0], rsp.result_value);
                    errors++;
                end
                void'(want_q.pop_front());
            end
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CycleLimit)
            begin
                $display("%0t: timeout", $time);
                $display("gf2_15_field_alu_core_tb: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        wait (feed_done === 1'b1);
        while (want_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
        if (errors == 0)
        begin
            $display("gf2_15_field_alu_core_tb: done, clean");
        end
        else
        begin
            $display("gf2_15_field_alu_core_tb: done, errors");
        end
        $finish;
    end
endmodule
